// ----- design/cup_pkg.sv -----
package cup_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE_LIT = 2'd0,
    MODE_WRITE_VAR = 2'd1,
    MODE_PROPAGATE = 2'd2,
    MODE_READ_VAR  = 2'd3
  } mode_t;

  // per-clause scan summary handed from the evaluator to the sequencer
  typedef struct packed {
    logic any_true;
    logic all_false;
    logic unit;
  } clause_verdict_t;

endpackage

// ----- design/clause_unit_propagation_core.sv -----
// clause_unit_propagation_core: unit propagation over a clause memory
// write words go through S_WRITE and S_DONE to a result, read words through S_READ, S_READ2, S_DONE
// propagate: passes over clauses_in_use clauses until one implies nothing or a conflict is found;
//   each literal slot takes a clause read, then a variable read
// one word in flight at a time; in_stall is high while busy or a result waits
// reset (rst, synchronous) clears control and the register, then the S_CLEAR pass clears every var entry
module clause_unit_propagation_core #(
  parameter int MAX_VARS    = 256,
  parameter int MAX_CLAUSES = 1024,
  parameter int MAX_LITS    = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [9:0]  clause_index,
  input  logic [2:0]  literal_slot,
  input  logic        literal_present,
  input  logic        literal_negated,
  input  logic [7:0]  var_index,
  input  logic        var_assigned,
  input  logic        var_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        conflict_found,
  output logic [9:0]  conflict_clause,
  output logic [8:0]  implied_count,
  output logic        read_assigned,
  output logic        read_value
);
  import cup_pkg::*;

  localparam int VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int CW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
  localparam int SW = (MAX_LITS > 1) ? $clog2(MAX_LITS) : 1;
  localparam int CNTW = $clog2(MAX_CLAUSES + 1);
  localparam int SCW = $clog2(MAX_LITS + 1);
  localparam int AW = CW + SW;
  localparam int LW = 2 + VW;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_WRITE, S_READ, S_READ2, S_PASS, S_ISSUE, S_WAIT, S_LIT,
    S_VAR, S_VLOOK, S_DECIDE, S_UNITRD, S_UNITWAIT, S_UNITSET, S_DONE
  } state_t;

  state_t state;

  // configuration, saturated to the clause memory depth
  logic [CNTW-1:0] clauses_in_use;
  always_ff @(posedge clk) begin
    if (rst) begin
      clauses_in_use <= '0;
    end else if (cfg_we) begin
      if (cfg_wdata > 11'(MAX_CLAUSES)) begin
        clauses_in_use <= CNTW'(MAX_CLAUSES);
      end else begin
        clauses_in_use <= CNTW'(cfg_wdata);
      end
    end
  end

  // captured input word
  mode_t        op;
  logic [CW-1:0] w_clause;
  logic [SW-1:0] w_slot;
  logic          w_present;
  logic          w_negated;
  logic [VW-1:0] w_var;
  logic          w_assigned;
  logic          w_value;

  // sequencer registers
  logic [CNTW-1:0] clause_ptr;
  logic [SCW-1:0]  slot_ptr;
  logic            changed;
  logic [8:0]      implied;
  logic [VW-1:0]   clr_ptr;

  // clause memory: {present, negated, var}
  logic          lit_we;
  logic [AW-1:0] lit_waddr;
  logic [AW-1:0] lit_raddr;
  logic [LW-1:0] lit_rdata;
  logic [LW-1:0] lit_wdata;

  assign lit_we    = (state == S_WRITE) && (op == MODE_WRITE_LIT);
  assign lit_waddr = {w_clause, w_slot};
  assign lit_wdata = {w_present, w_negated, w_var};

  cup_ram #(.WIDTH(LW), .DEPTH(MAX_CLAUSES * MAX_LITS)) u_lits (
    .clk     (clk),
    .wr_en   (lit_we),
    .wr_addr (lit_waddr),
    .wr_data (lit_wdata),
    .rd_addr (lit_raddr),
    .rd_data (lit_rdata)
  );

  // literal from the clause memory read port
  logic          l_present;
  logic          l_negated;
  logic [VW-1:0] l_var;

  assign l_present = lit_rdata[LW-1];
  assign l_negated = lit_rdata[LW-2];
  assign l_var     = lit_rdata[VW-1:0];

  // assignment store: {assigned, value}, cleared by a pass after reset
  logic          var_we;
  logic [VW-1:0] var_waddr;
  logic [1:0]    var_wdata;
  logic [VW-1:0] var_raddr;
  logic [1:0]    var_rdata;

  always_comb begin
    var_we    = 1'b0;
    var_waddr = l_var;
    var_wdata = {1'b1, ~l_negated};
    case (state)
      S_CLEAR: begin
        var_we    = 1'b1;
        var_waddr = clr_ptr;
        var_wdata = 2'b00;
      end
      S_WRITE: begin
        var_we    = (op == MODE_WRITE_VAR);
        var_waddr = w_var;
        var_wdata = {w_assigned, w_assigned & w_value};
      end
      S_UNITWAIT: begin
        // unit literal made true
        var_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // read word looks up its own variable, the clause walk looks up the literal's
  always_comb begin
    if (state == S_READ) begin
      var_raddr = w_var;
    end else begin
      var_raddr = l_var;
    end
  end

  cup_ram #(.WIDTH(2), .DEPTH(MAX_VARS)) u_vars (
    .clk     (clk),
    .wr_en   (var_we),
    .wr_addr (var_waddr),
    .wr_data (var_wdata),
    .rd_addr (var_raddr),
    .rd_data (var_rdata)
  );

  // registered lookup result feeding the evaluator
  logic          e_valid;
  logic          e_present;
  logic          e_assigned;
  logic          e_true;
  logic [SCW-1:0] e_slot;

  clause_verdict_t verdict;
  logic [SCW-1:0]  free_slot;
  logic            eval_clear;

  assign eval_clear = (state == S_ISSUE);

  cup_eval #(.MAX_LITS(MAX_LITS)) u_eval (
    .clk          (clk),
    .clear        (eval_clear),
    .lit_valid    (e_valid),
    .lit_present  (e_present),
    .lit_assigned (e_assigned),
    .lit_true     (e_true),
    .slot         (e_slot),
    .verdict      (verdict),
    .free_slot    (free_slot)
  );

  // read address: walking slot, or the chosen unit slot
  logic [CW-1:0] cur_clause;
  assign cur_clause = clause_ptr[CW-1:0];
  always_comb begin
    if (state == S_UNITRD) begin
      lit_raddr = {cur_clause, free_slot[SW-1:0]};
    end else begin
      lit_raddr = {cur_clause, slot_ptr[SW-1:0]};
    end
  end

  assign in_stall = (state != S_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_ptr    <= '0;
      out_valid  <= 1'b0;
      e_valid    <= 1'b0;
      clause_ptr <= '0;
      slot_ptr   <= '0;
      changed    <= 1'b0;
      implied    <= '0;
    end else begin
      if (state == S_DONE) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      e_valid <= (state == S_VAR);
      case (state)
        S_CLEAR: begin
          // one variable entry cleared per cycle
          if (clr_ptr == VW'(MAX_VARS - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_ptr <= clr_ptr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op         <= mode_t'(mode);
            w_clause   <= CW'(clause_index);
            w_slot     <= SW'(literal_slot);
            w_present  <= literal_present;
            w_negated  <= literal_negated;
            w_var      <= VW'(var_index);
            w_assigned <= var_assigned;
            w_value    <= var_value;
            case (mode_t'(mode))
              MODE_PROPAGATE: begin
                state <= S_PASS;
              end
              MODE_READ_VAR: begin
                state <= S_READ;
              end
              default: begin
                state <= S_WRITE;
              end
            endcase
          end
        end
        S_WRITE: begin
          // memory writes happen on the ports above
          conflict_found  <= 1'b0;
          conflict_clause <= '0;
          implied_count   <= '0;
          read_assigned   <= 1'b0;
          read_value      <= 1'b0;
          state           <= S_DONE;
        end
        S_READ: begin
          // variable read in flight
          state <= S_READ2;
        end
        S_READ2: begin
          conflict_found  <= 1'b0;
          conflict_clause <= '0;
          implied_count   <= '0;
          read_assigned   <= var_rdata[1];
          read_value      <= var_rdata[1] & var_rdata[0];
          state           <= S_DONE;
        end
        S_PASS: begin
          // start of the whole run
          clause_ptr <= '0;
          changed    <= 1'b0;
          if (clauses_in_use == '0) begin
            conflict_found  <= 1'b0;
            conflict_clause <= '0;
            implied_count   <= implied;
            read_assigned   <= 1'b0;
            read_value      <= 1'b0;
            state           <= S_DONE;
          end else begin
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          // evaluator cleared; first slot address follows
          slot_ptr <= '0;
          state    <= S_WAIT;
        end
        S_WAIT: begin
          // clause memory read in flight for slot_ptr
          state <= S_LIT;
        end
        S_LIT: begin
          // literal present: its variable is being read
          state <= S_VAR;
        end
        S_VAR: begin
          // literal and variable both present: hand them to the evaluator
          e_present  <= l_present;
          e_assigned <= var_rdata[1];
          e_true     <= var_rdata[0] ^ l_negated;
          e_slot     <= slot_ptr;
          if (slot_ptr == SCW'(MAX_LITS - 1)) begin
            state <= S_VLOOK;
          end else begin
            slot_ptr <= slot_ptr + 1'b1;
            state    <= S_WAIT;
          end
        end
        S_VLOOK: begin
          // last literal folding into the evaluator
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (verdict.any_true) begin
            state <= S_UNITSET;
          end else if (verdict.all_false) begin
            conflict_found  <= 1'b1;
            conflict_clause <= 10'(clause_ptr);
            implied_count   <= implied;
            read_assigned   <= 1'b0;
            read_value      <= 1'b0;
            state           <= S_DONE;
          end else if (verdict.unit) begin
            state <= S_UNITRD;
          end else begin
            state <= S_UNITSET;
          end
        end
        S_UNITRD: begin
          state <= S_UNITWAIT;
        end
        S_UNITWAIT: begin
          // unit literal back from memory, written true through the variable port
          implied <= implied + 1'b1;
          changed <= 1'b1;
          state   <= S_UNITSET;
        end
        S_UNITSET: begin
          // advance to the next clause, or close the pass
          if (clause_ptr + 1'b1 == clauses_in_use) begin
            if (changed) begin
              clause_ptr <= '0;
              changed    <= 1'b0;
              state      <= S_ISSUE;
            end else begin
              conflict_found  <= 1'b0;
              conflict_clause <= '0;
              implied_count   <= implied;
              read_assigned   <= 1'b0;
              read_value      <= 1'b0;
              state           <= S_DONE;
            end
          end else begin
            clause_ptr <= clause_ptr + 1'b1;
            state      <= S_ISSUE;
          end
        end
        S_DONE: begin
          implied <= '0;
          state   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result never appears while a word is still being worked on
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_IDLE))
    else $error("result valid while busy");

  // a waiting result is held until taken
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(implied_count)))
    else $error("stalled result changed");

  // the clause walk stays inside the configured range
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> (clause_ptr < clauses_in_use))
    else $error("clause pointer out of range");

  // a conflict is only reported by a propagate word
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && conflict_found |-> (op == MODE_PROPAGATE))
    else $error("conflict on non-propagate word");

endmodule

// ----- design/cup_ram.sv -----
module cup_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/cup_eval.sv -----
module cup_eval #(
  parameter int MAX_LITS = 8
) (
  input  logic                        clk,
  input  logic                        clear,
  input  logic                        lit_valid,
  input  logic                        lit_present,
  input  logic                        lit_assigned,
  input  logic                        lit_true,
  input  logic [$clog2(MAX_LITS+1)-1:0] slot,
  output cup_pkg::clause_verdict_t    verdict,
  output logic [$clog2(MAX_LITS+1)-1:0] free_slot
);
  import cup_pkg::*;

  // counting unit: folds one present literal per cycle into the clause summary; clear takes priority
  logic       any_true;
  logic [$clog2(MAX_LITS+1)-1:0] n_total;
  logic [$clog2(MAX_LITS+1)-1:0] n_false;
  logic       have_free;

  always_ff @(posedge clk) begin
    if (clear) begin
      any_true  <= 1'b0;
      n_total   <= '0;
      n_false   <= '0;
      have_free <= 1'b0;
      free_slot <= '0;
    end else if (lit_valid && lit_present) begin
      n_total <= n_total + 1'b1;
      if (lit_assigned) begin
        if (lit_true) begin
          any_true <= 1'b1;
        end else begin
          n_false <= n_false + 1'b1;
        end
      end else if (!have_free) begin
        have_free <= 1'b1;
        free_slot <= slot;
      end
    end
  end

  assign verdict.any_true  = any_true;
  assign verdict.all_false = !any_true && (n_false == n_total);
  assign verdict.unit      = !any_true && (n_false + 1'b1 == n_total);

endmodule
